@@ hw/rtl/mrkb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrkb_pkg: shared types, constants and functions
// Key schedule constants, the queue item type and the masking helpers.
// ----------------------------------------------------------------------------
package mrkb_pkg;

    localparam int ROUNDS       = 32;
    localparam int RCNT_W       = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int RIDX_W       = 5;
    localparam int KEY_W        = 64;
    localparam int RAND_W       = 32;
    localparam int WORD_W       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int M_TDATA_W    = 136;

    // new nibble j takes old nibble NIB_PERM[j]
    localparam logic [3:0] NIB_PERM [16] = '{4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14,
                                            4'd12, 4'd11, 4'd0, 4'd1, 4'd2, 4'd3,
                                            4'd4, 4'd5, 4'd6, 4'd7};
    localparam logic [3:0] PARITY_FLIP = 4'hF;

    // One classified round: low key nibbles, mask nibbles and round tags
    typedef struct packed {
        logic [WORD_W-1:0] key_lo;
        logic [RAND_W-1:0] rnd;
        logic [RIDX_W-1:0] ridx;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [KEY_W-1:0] permute_state(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] res;
        res = '0;
        for (int j = 0; j < 16; j++) begin
            res[4*j +: 4] = v[4*NIB_PERM[j] +: 4];
        end
        return res;
    endfunction

    // L(r) = r ^ (parity(r) ? F : 0)
    function automatic logic [3:0] lin_mask(input logic [3:0] r);
        return r ^ (^r ? PARITY_FLIP : 4'h0);
    endfunction

    function automatic logic [15:0] ror16(input logic [15:0] x, input int s);
        logic [31:0] dbl;
        dbl = {x, x} >> s;
        return dbl[15:0];
    endfunction

endpackage

@@ hw/rtl/masked_round_key_bitslicer.sv @@
// ----------------------------------------------------------------------------
// masked_round_key_bitslicer: masked SKINNY-64-64 round-key bitslicer
// Turns per-round mask nibbles into two-share bitsliced round keys.
// ----------------------------------------------------------------------------
// One mask word in, one round key out, at a sustained rate of one transfer
// per cycle while m_tready stays high; a mask word passes through the queue
// and then the back stage's output register, which raises m_tvalid. The
// front stage holds the 16-nibble key state and the round counter and
// steps them on every accepted word; round 0 reloads from cipher_key, later
// rounds apply the fixed nibble permutation, and the counter wraps after
// ROUNDS-1. A two-entry queue decouples it from the back stage, which
// masks the low eight key nibbles (share1 = r, share0 = w ^ L(r)), gathers
// and rotates the bit planes and holds the result in an output register
// that refills in the same cycle it is drained. A key write takes effect
// at the next round 0; write it only while no rounds are in flight.
// ----------------------------------------------------------------------------
module masked_round_key_bitslicer
(
    input  logic         clk,
    input  logic         rst_n,
    // key register write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data,     // cipher_key
    // mask nibble stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,      // [31:0] rand_nibbles
    // round key stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,      // [31:0] share0_word_ab, [63:32] share0_word_cd,
                                       // [95:64] share1_word_ab, [127:96] share1_word_cd,
                                       // [132:128] round_index, [135:133] zero
    output logic         m_tlast       // last_round
);
    import mrkb_pkg::*;

    logic [KEY_W-1:0] cipher_key_reg;
    logic             push;
    logic             pop;
    item_t            push_item;
    item_t            head_item;
    q_stat_t          q_stat;

    // key register: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cipher_key_reg <= cfg_data;
        end
    end

    mrkb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cipher_key (cipher_key_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_rand    (s_tdata),
        .q_full     (q_stat.full),
        .push       (push),
        .push_item  (push_item)
    );

    mrkb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // back stage pops whenever its output register can take the head
    logic back_ready;
    assign pop = !q_stat.empty && back_ready;

    mrkb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_stat.empty),
        .in_ready  (back_ready),
        .in_item   (head_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // final-round flag only on the last round number
    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[132:128] == RIDX_W'(ROUNDS - 1))
        else $error("tlast on a round other than the final one");

    // queue occupancy never exceeds its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // a queued round reaches an empty output register in the next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !m_tvalid |=> m_tvalid)
        else $error("back stage stalled with free output register");

    // nothing pushed while the queue is full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/mrkb_front.sv @@
// ----------------------------------------------------------------------------
// mrkb_front: input stage of the round-key bitslicer
// Accepts mask words, steps the key state and round counter, tags each round.
// ----------------------------------------------------------------------------
module mrkb_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mrkb_pkg::KEY_W-1:0]  cipher_key,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mrkb_pkg::RAND_W-1:0] in_rand,
    input  logic                        q_full,
    output logic                        push,
    output mrkb_pkg::item_t             push_item
);
    import mrkb_pkg::*;

    logic [KEY_W-1:0]  tk_state_reg, tk_state_next;
    logic [RCNT_W-1:0] round_cnt_reg, round_cnt_next;
    logic [KEY_W-1:0]  cur_key;
    logic              is_last;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // round 0 restarts from the programmed key
    assign cur_key = (round_cnt_reg == '0) ? cipher_key : tk_state_reg;
    assign is_last = (round_cnt_reg == RCNT_W'(ROUNDS - 1));

    always_comb
    begin
        push_item.key_lo = cur_key[WORD_W-1:0];
        push_item.rnd    = in_rand;
        push_item.ridx   = RIDX_W'(round_cnt_reg);
        push_item.last   = is_last;

        tk_state_next  = tk_state_reg;
        round_cnt_next = round_cnt_reg;
        if (push)
        begin
            tk_state_next  = permute_state(cur_key);
            round_cnt_next = is_last ? '0 : round_cnt_reg + RCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk_state_reg  <= '0;
            round_cnt_reg <= '0;
        end
        else
        begin
            tk_state_reg  <= tk_state_next;
            round_cnt_reg <= round_cnt_next;
        end
    end

endmodule

@@ hw/rtl/mrkb_queue.sv @@
// ----------------------------------------------------------------------------
// mrkb_queue: short FIFO between front and back
// Register-based, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module mrkb_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrkb_pkg::item_t   push_item,
    input  logic              pop,
    output mrkb_pkg::item_t   head_item,
    output mrkb_pkg::q_stat_t stat
);
    import mrkb_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head_item  = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/mrkb_back.sv @@
// ----------------------------------------------------------------------------
// mrkb_back: masking and bitslice stage
// Builds both shares, gathers bit planes, rotates, registers the result.
// ----------------------------------------------------------------------------
module mrkb_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mrkb_pkg::item_t                   in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mrkb_pkg::M_TDATA_W-1:0]    out_data,
    output logic                              out_last
);
    import mrkb_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  out_last_reg;
    logic [M_TDATA_W-1:0]  data_next;
    logic [7:0]            pl0 [4];
    logic [7:0]            pl1 [4];
    logic [15:0]           rot0 [4];
    logic [15:0]           rot1 [4];
    logic                  take;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        logic [3:0] r;
        logic [3:0] s0;
        for (int p = 0; p < 4; p++)
        begin
            pl0[p] = '0;
            pl1[p] = '0;
        end
        for (int j = 0; j < 8; j++)
        begin
            r  = in_item.rnd[4*j +: 4];
            s0 = in_item.key_lo[4*j +: 4] ^ lin_mask(r);
            for (int p = 0; p < 4; p++)
            begin
                pl0[p][j] = s0[p];
                pl1[p][j] = r[p];
            end
        end
        // share 0 planes rotate by 0..3, share 1 planes by 4..7
        for (int p = 0; p < 4; p++)
        begin
            rot0[p] = ror16({8'h00, pl0[p]}, p);
            rot1[p] = ror16({8'h00, pl1[p]}, p + 4);
        end
        data_next = {3'b000, in_item.ridx,
                     rot1[3], rot1[2], rot1[1], rot1[0],
                     rot0[3], rot0[2], rot0[1], rot0[0]};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= data_next;
            out_last_reg <= in_item.last;
        end
    end

endmodule
